FILE: src/drr_pkg.sv
// Package for the 27-direction ranker: payload structs, internal entry types,
// widths and the lattice direction table. Depends on nothing.
package drr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int NUM_DIRS  = 27;
    localparam int IDX_W     = 5;
    localparam int VEC_W     = 16;
    localparam int COMP_W    = 17;   // signed direction component
    localparam int DIFF_W    = 18;   // signed component difference
    localparam int ABS_W     = 17;   // magnitude of a difference
    localparam int SQ_W      = 2 * ABS_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int RES_W     = SUM_W + 1;
    localparam int SCORE_W   = 18;   // emitted, saturated
    localparam int SCORE_EW  = ROOT_W + 2; // exact, signed
    localparam int CNT_W     = 5;

    // Q32 reciprocal roots rounded to FRAC_BITS fraction bits
    localparam longint unsigned INV_SQRT2_Q32 = 64'd3037000500;
    localparam longint unsigned INV_SQRT3_Q32 = 64'd2479700525;
    localparam longint unsigned MAG1 = 64'd1 << FRAC_BITS;
    localparam longint unsigned MAG2 =
        (INV_SQRT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam longint unsigned MAG3 =
        (INV_SQRT3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    localparam logic signed [SCORE_EW-1:0] SCORE_TWO =
        SCORE_EW'(longint'(2) << FRAC_BITS);
    localparam logic signed [SCORE_EW-1:0] SCORE_MAX = SCORE_EW'(131071);
    localparam logic signed [SCORE_EW-1:0] SCORE_MIN = -SCORE_EW'(131072);

    // sign codes of the direction table
    localparam logic [1:0] S_ZERO = 2'b00;
    localparam logic [1:0] S_POS  = 2'b01;
    localparam logic [1:0] S_NEG  = 2'b11;

    localparam logic [1:0] DIR_SGN [NUM_DIRS][3] = '{
        '{S_ZERO, S_ZERO, S_ZERO},
        '{S_NEG,  S_ZERO, S_ZERO}, '{S_ZERO, S_NEG,  S_ZERO}, '{S_ZERO, S_ZERO, S_NEG },
        '{S_ZERO, S_ZERO, S_POS }, '{S_ZERO, S_POS,  S_ZERO}, '{S_POS,  S_ZERO, S_ZERO},
        '{S_NEG,  S_NEG,  S_ZERO}, '{S_NEG,  S_ZERO, S_NEG }, '{S_NEG,  S_ZERO, S_POS },
        '{S_NEG,  S_POS,  S_ZERO}, '{S_ZERO, S_NEG,  S_NEG }, '{S_ZERO, S_NEG,  S_POS },
        '{S_ZERO, S_POS,  S_NEG }, '{S_ZERO, S_POS,  S_POS }, '{S_POS,  S_NEG,  S_ZERO},
        '{S_POS,  S_ZERO, S_NEG }, '{S_POS,  S_ZERO, S_POS }, '{S_POS,  S_POS,  S_ZERO},
        '{S_NEG,  S_NEG,  S_NEG }, '{S_NEG,  S_NEG,  S_POS }, '{S_NEG,  S_POS,  S_NEG },
        '{S_NEG,  S_POS,  S_POS }, '{S_POS,  S_NEG,  S_NEG }, '{S_POS,  S_NEG,  S_POS },
        '{S_POS,  S_POS,  S_NEG }, '{S_POS,  S_POS,  S_POS }
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } t_in_req;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          dir_num;
        logic                      last;
    } t_out_req;

    // one ranked entry held by a sorter cell
    typedef struct packed {
        logic                       v;
        logic signed [SCORE_EW-1:0] score;
        logic [IDX_W-1:0]           idx;
    } t_entry;

    // sorter cell controls, common to the whole row
    typedef struct packed {
        logic ins;
        logic load;
        logic shift;
    } t_cell_ctl;

    // square-root pipeline word
    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] k;
        logic [RES_W-1:0] n;
        logic [RES_W-1:0] res;
    } t_sq;

    // signed component of direction k on one axis
    function automatic logic signed [COMP_W-1:0] dir_comp(input logic [IDX_W-1:0] k,
                                                          input int a);
        logic [1:0] sg;
        int nz;
        logic signed [COMP_W-1:0] mag;
        sg  = S_ZERO;
        nz  = 0;
        mag = '0;
        if (k < IDX_W'(NUM_DIRS)) begin
            sg = DIR_SGN[k][a];
            for (int j = 0; j < 3; j++) begin
                if (DIR_SGN[k][j] != S_ZERO) nz++;
            end
        end
        case (nz)
            1: mag = COMP_W'(MAG1);
            2: mag = COMP_W'(MAG2);
            3: mag = COMP_W'(MAG3);
            default: mag = '0;
        endcase
        case (sg)
            S_POS: return mag;
            S_NEG: return -mag;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: src/drr_sqrt_step.sv
// One registered step of the pipelined integer square root (one result bit).
// Depends on drr_pkg.
module drr_sqrt_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic [drr_pkg::RES_W-1:0] i_bit,
    input  drr_pkg::t_sq              i_d,
    output drr_pkg::t_sq              o_d
);
    import drr_pkg::*;

    t_sq              r_d;
    t_sq              n_d;
    logic [RES_W-1:0] trial;

    // trial subtract, shift the partial root
    always_comb begin
        trial = i_d.res + i_bit;
        n_d   = i_d;
        if (i_d.n >= trial) begin
            n_d.n   = i_d.n - trial;
            n_d.res = (i_d.res >> 1) + i_bit;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.v <= 1'b0;
        end else if (i_adv) begin
            r_d.v <= i_d.v;
        end
        if (i_adv) begin
            r_d.k   <= n_d.k;
            r_d.n   <= n_d.n;
            r_d.res <= n_d.res;
        end
    end

    assign o_d = r_d;

endmodule

FILE: src/drr_cell.sv
// One cell of the ranking row: an insertion-sort slot plus an output shift slot.
// Depends on drr_pkg.
module drr_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drr_pkg::t_cell_ctl i_ctl,
    input  drr_pkg::t_entry    i_new,
    input  drr_pkg::t_entry    i_left,
    input  logic               i_left_bef,
    input  drr_pkg::t_entry    i_right_out,
    output logic               o_bef,
    output drr_pkg::t_entry    o_held,
    output drr_pkg::t_entry    o_out
);
    import drr_pkg::*;

    t_entry r_held;
    t_entry n_held;
    t_entry r_out;
    t_entry n_out;
    logic   held_v;

    // a load empties the row for the next vector
    assign held_v = r_held.v && !i_ctl.load;
    // newer entries carry larger indexes, so ties go in front
    assign o_bef  = !held_v || (i_new.score >= r_held.score);

    always_comb begin
        n_held   = r_held;
        n_held.v = held_v;
        if (i_ctl.ins && o_bef) begin
            if (!i_left_bef) begin
                n_held   = i_new;
                n_held.v = 1'b1;
            end else begin
                n_held   = i_left;
                n_held.v = i_left.v && !i_ctl.load;
            end
        end
    end

    // output row: parallel load, then shift toward the head
    always_comb begin
        n_out = r_out;
        if (i_ctl.load) begin
            n_out = r_held;
        end else if (i_ctl.shift) begin
            n_out = i_right_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.v <= 1'b0;
        end else begin
            r_held.v <= n_held.v;
        end
        r_held.score <= n_held.score;
        r_held.idx   <= n_held.idx;
        r_out        <= n_out;
    end

    assign o_held = r_held;
    assign o_out  = r_out;

endmodule

FILE: src/direction_ranker_27.sv
// Top level of the 27-direction ranker: direction sequencer, distance pipeline,
// square-root chain and ranking row. Depends on drr_pkg, drr_sqrt_step, drr_cell.
//
// Each request (vec_x, vec_y, vec_z) yields 27 responses, (score, direction number)
// in descending score order with ties going larger index first, and last set
// on the 27th. A sequencer walks the 27 directions at one per cycle while the
// pipeline advances, and takes a new vector as its last direction advances; a row
// of 27 insertion cells ranks them as they arrive, and a parallel output row
// drains the previous vector meanwhile, one response per cycle unless stalled.
// A request passes the sequencer, 3 arithmetic stages, 18 root steps and a load.
module direction_ranker_27 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  drr_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output drr_pkg::t_out_req o_out_req
);
    import drr_pkg::*;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] k;
        logic [ABS_W-1:0] ax;
        logic [ABS_W-1:0] ay;
        logic [ABS_W-1:0] az;
    } t_s1;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] k;
        logic [SQ_W-1:0]  qx;
        logic [SQ_W-1:0]  qy;
        logic [SQ_W-1:0]  qz;
    } t_s2;

    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(NUM_DIRS - 1);
    localparam logic [CNT_W-1:0] N_FULL = CNT_W'(NUM_DIRS);

    t_in_req          r_vec;
    logic [IDX_W-1:0] r_k;
    logic             r_busy;
    t_s1              r_s1;
    t_s1              n_s1;
    t_s2              r_s2;
    t_sq              r_s3;
    t_sq              sq_d [ROOT_W+1];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_oc;

    logic             adv;
    logic             in_acc;
    logic             load;
    logic             shift;
    logic             take;
    t_cell_ctl        ctl;
    t_entry           new_ent;
    t_entry           held [NUM_DIRS];
    t_entry           outv [NUM_DIRS+1];
    logic             bef  [NUM_DIRS+1];
    logic signed [SCORE_EW-1:0] head_score;

    // handshake and row control
    assign shift       = o_out_valid && !i_out_stall;
    assign load        = (r_cnt == N_FULL) &&
                         ((r_oc == '0) || ((r_oc == CNT_W'(1)) && shift));
    assign take        = (r_cnt != N_FULL) || load;
    assign new_ent.v   = sq_d[ROOT_W].v;
    assign new_ent.idx = sq_d[ROOT_W].k;
    assign new_ent.score = SCORE_TWO -
                           SCORE_EW'(sq_d[ROOT_W].res[ROOT_W-1:0]);
    assign adv         = !sq_d[ROOT_W].v || take;
    assign ctl.ins     = sq_d[ROOT_W].v && take;
    assign ctl.load    = load;
    assign ctl.shift   = shift;
    assign o_in_stall  = r_busy && !(adv && (r_k == K_LAST));
    assign in_acc      = i_in_valid && !o_in_stall;

    // direction sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (adv && r_busy) begin
            r_k <= r_k + IDX_W'(1);
            if (r_k == K_LAST) r_busy <= 1'b0;
        end
        if (in_acc) r_vec <= i_in_req;
    end

    // stage 1: component differences
    always_comb begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        dx = DIFF_W'(r_vec.vec_x) - DIFF_W'(dir_comp(r_k, 0));
        dy = DIFF_W'(r_vec.vec_y) - DIFF_W'(dir_comp(r_k, 1));
        dz = DIFF_W'(r_vec.vec_z) - DIFF_W'(dir_comp(r_k, 2));
        n_s1.v  = r_busy;
        n_s1.k  = r_k;
        n_s1.ax = ABS_W'(dx < 0 ? -dx : dx);
        n_s1.ay = ABS_W'(dy < 0 ? -dy : dy);
        n_s1.az = ABS_W'(dz < 0 ? -dz : dz);
    end

    // stages 1..3: differences, squares, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
            r_s2.v <= 1'b0;
            r_s3.v <= 1'b0;
        end else if (adv) begin
            r_s1.v <= n_s1.v;
            r_s2.v <= r_s1.v;
            r_s3.v <= r_s2.v;
        end
        if (adv) begin
            r_s1.k    <= n_s1.k;
            r_s1.ax   <= n_s1.ax;
            r_s1.ay   <= n_s1.ay;
            r_s1.az   <= n_s1.az;
            r_s2.k    <= r_s1.k;
            r_s2.qx   <= SQ_W'(r_s1.ax) * SQ_W'(r_s1.ax);
            r_s2.qy   <= SQ_W'(r_s1.ay) * SQ_W'(r_s1.ay);
            r_s2.qz   <= SQ_W'(r_s1.az) * SQ_W'(r_s1.az);
            r_s3.k    <= r_s2.k;
            r_s3.n    <= RES_W'(r_s2.qx) + RES_W'(r_s2.qy) + RES_W'(r_s2.qz);
            r_s3.res  <= '0;
        end
    end

    // truncating square root, one result bit per step
    assign sq_d[0] = r_s3;
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        drr_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_bit   (RES_W'(1) << (2 * (ROOT_W - 1 - j))),
            .i_d     (sq_d[j]),
            .o_d     (sq_d[j+1])
        );
    end

    // ranking row
    assign bef[0]           = 1'b0;
    assign outv[NUM_DIRS]   = '0;
    for (genvar i = 0; i < NUM_DIRS; i++) begin : g_cell
        drr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new       (new_ent),
            .i_left      (i == 0 ? new_ent : held[(i == 0) ? 0 : i-1]),
            .i_left_bef  (bef[i]),
            .i_right_out (outv[i+1]),
            .o_bef       (bef[i+1]),
            .o_held      (held[i]),
            .o_out       (outv[i])
        );
    end

    // fill and drain counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_oc  <= '0;
        end else begin
            if (load) begin
                r_cnt <= ctl.ins ? CNT_W'(1) : '0;
                r_oc  <= N_FULL;
            end else begin
                r_cnt <= r_cnt + CNT_W'(ctl.ins);
                r_oc  <= r_oc - CNT_W'(shift);
            end
        end
    end

    // response at the head of the output row, score saturated
    assign head_score            = outv[0].score;
    assign o_out_valid           = (r_oc != '0);
    assign o_out_req.dir_num     = outv[0].idx;
    assign o_out_req.last        = (r_oc == CNT_W'(1));
    assign o_out_req.score       = (head_score > SCORE_MAX) ? SCORE_W'(SCORE_MAX) :
                                   (head_score < SCORE_MIN) ? SCORE_W'(SCORE_MIN) :
                                   SCORE_W'(head_score);

endmodule
